[hw/rtl/swe_pkg.sv]
// Shared constants, types and state codes for the stereo width expander.
package swe_pkg;

    // Default geometry of the sample path and of the width factor.
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int WIDTH_FRAC_BITS_DEF = 14;

    // Width register: unsigned, reset value is 1.0 in Q2.14.
    localparam int              CFG_BITS    = 16;
    localparam logic [15:0]     WIDTH_RESET = 16'd16384;

    // Output gain g in unsigned Q2.16, capped at its full scale.
    localparam int               GAIN_BITS = 18;
    localparam logic [17:0]      GAIN_MAX  = 18'h3ffff;

    // Quotient of the gain calculation never exceeds 2^33.
    localparam int QUO_BITS = 34;

    // (mid2 +- side) * g carries one extra bit from mid2 and 16 from g.
    localparam int OUT_SHIFT = 17;

    // Gain calculation sequencer states.
    typedef enum logic [2:0] {
        GS_IDLE,
        GS_SQUARE,
        GS_DIVIDE,
        GS_ROOT,
        GS_FINISH
    } t_gain_state;

    // Request from the register side to the gain unit.
    typedef struct packed {
        logic                start;
        logic [CFG_BITS-1:0] width;
    } t_gain_req;

    // Status of the gain unit towards the sample path.
    typedef struct packed {
        logic                 busy;
        logic [GAIN_BITS-1:0] gain;
    } t_gain_stat;

endpackage

[hw/rtl/swe_frame_in_if.sv]
// Input frame channel: one stereo frame per beat.
interface swe_frame_in_if #(
    parameter int SAMPLE_BITS = swe_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          block_end;

    modport source (output valid, left_sample, right_sample, block_end, input ready);
    modport sink   (input valid, left_sample, right_sample, block_end, output ready);
endinterface

[hw/rtl/swe_frame_out_if.sv]
// Output frame channel: one widened stereo frame per beat.
interface swe_frame_out_if #(
    parameter int SAMPLE_BITS = swe_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_result;
    logic signed [SAMPLE_BITS-1:0] right_result;
    logic                          block_end_out;

    modport source (output valid, left_result, right_result, block_end_out, input ready);
    modport sink   (input valid, left_result, right_result, block_end_out, output ready);
endinterface

[hw/rtl/swe_cfg_if.sv]
// Configuration write channel carrying the width register.
interface swe_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [swe_pkg::CFG_BITS-1:0]  width_gain;

    modport source (output valid, width_gain, input ready);
    modport sink   (input valid, width_gain, output ready);
endinterface

[hw/rtl/swe_gain.sv]
// Sequential unit computing g = round(sqrt(2^(33+2F) / (2^2F + w^2))).
module swe_gain #(
    parameter int WIDTH_FRAC_BITS = swe_pkg::WIDTH_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swe_pkg::t_gain_req i_req,
    output swe_pkg::t_gain_stat o_stat
);
    import swe_pkg::*;

    localparam int STEPS = 33 + 2 * WIDTH_FRAC_BITS;
    localparam int CW    = $clog2(STEPS);
    localparam int NW    = QUO_BITS;

    localparam logic [NW-1:0] DEN_ONE  = NW'(1) << (2 * WIDTH_FRAC_BITS);
    localparam logic [NW-1:0] BIT_TOP  = NW'(1) << (NW - 2);
    localparam logic [CW-1:0] CNT_LAST = CW'(STEPS - 1);

    t_gain_state          r_state, n_state;
    logic [NW-1:0]        r_den, n_den;
    logic [NW-1:0]        r_acc, n_acc;
    logic [NW-1:0]        r_quo, n_quo;
    logic [NW:0]          r_root, n_root;
    logic [NW-1:0]        r_bit, n_bit;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [GAIN_BITS-1:0] r_gain, n_gain;

    logic [NW-1:0] w_shifted;
    logic [NW:0]   w_trial;
    logic [NW+1:0] w_round;

    // State register; reset starts a calculation for the reset width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GS_SQUARE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers of the divider and the square root.
    always_ff @(posedge i_clk) begin
        r_den  <= n_den;
        r_acc  <= n_acc;
        r_quo  <= n_quo;
        r_root <= n_root;
        r_bit  <= n_bit;
        r_cnt  <= n_cnt;
        r_gain <= n_gain;
    end

    // Next state: square, restoring division one bit a cycle, root two bits a cycle, round.
    always_comb begin
        n_state = r_state;
        n_den   = r_den;
        n_acc   = r_acc;
        n_quo   = r_quo;
        n_root  = r_root;
        n_bit   = r_bit;
        n_cnt   = r_cnt;
        n_gain  = r_gain;

        w_shifted = {r_acc[NW-2:0], 1'b0};
        w_trial   = r_root + {1'b0, r_bit};
        w_round   = {1'b0, r_root} + ((r_quo > r_root[NW-1:0]) ? (NW+2)'(1) : '0);

        unique case (r_state)
            GS_IDLE: begin
                if (i_req.start) begin
                    n_state = GS_SQUARE;
                end
            end
            GS_SQUARE: begin
                n_den   = DEN_ONE + NW'(i_req.width) * NW'(i_req.width);
                n_acc   = NW'(1);
                n_quo   = '0;
                n_cnt   = '0;
                n_state = GS_DIVIDE;
            end
            GS_DIVIDE: begin
                if (w_shifted >= r_den) begin
                    n_acc = w_shifted - r_den;
                    n_quo = {r_quo[NW-2:0], 1'b1};
                end else begin
                    n_acc = w_shifted;
                    n_quo = {r_quo[NW-2:0], 1'b0};
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_root  = '0;
                    n_bit   = BIT_TOP;
                    n_state = GS_ROOT;
                end
            end
            GS_ROOT: begin
                if ({1'b0, r_quo} >= w_trial) begin
                    n_quo  = r_quo - w_trial[NW-1:0];
                    n_root = (r_root >> 1) + {1'b0, r_bit};
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_state = GS_FINISH;
                end
            end
            GS_FINISH: begin
                // Round to nearest: the leftover exceeds the root when past the half.
                if (w_round > (NW+2)'(GAIN_MAX)) begin
                    n_gain = GAIN_MAX;
                end else begin
                    n_gain = w_round[GAIN_BITS-1:0];
                end
                n_state = GS_IDLE;
            end
            default: begin
                n_state = GS_IDLE;
            end
        endcase
    end

    assign o_stat.busy = (r_state != GS_IDLE);
    assign o_stat.gain = r_gain;

endmodule

[hw/rtl/stereo_width_expander_core.sv]
// Top level of the mid/side stereo width expander with soft knee and gain.
//
// Channels: i_frame takes one stereo frame (left, right, block end) per beat,
// o_frame gives one widened frame per beat, in the same order, with the block
// end flag copied through. i_cfg writes the width factor (unsigned Q(16-F).F).
// Throughput: one frame per cycle while o_frame.ready is high and the gain unit
// is idle. The sample pipeline has twelve register stages (sum/difference,
// width multiply, round, knee compare, three divide-by-five stages, correction,
// knee, mid +- side, gain multiply, round and saturate).
// After each width write the gain unit is busy while it squares the width,
// divides, takes the square root and rounds; i_frame.ready stays low meanwhile.
// A width write is taken only when the pipeline is empty and the gain unit idle.
// Reset clears the pipeline, sets the width to 1.0 and starts the same gain
// calculation with the squaring done during reset, so i_frame.ready rises only
// once that calculation is done.
// When o_frame.ready is low each stage holds its frame, empty stages still fill,
// and i_frame.ready falls only once every stage holds a frame.
module stereo_width_expander_core #(
    parameter int SAMPLE_BITS     = swe_pkg::SAMPLE_BITS_DEF,
    parameter int WIDTH_FRAC_BITS = swe_pkg::WIDTH_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    swe_cfg_if.sink          i_cfg,
    swe_frame_in_if.sink     i_frame,
    swe_frame_out_if.source  o_frame
);
    import swe_pkg::*;

    localparam int NST = 12;
    localparam int DW  = SAMPLE_BITS + 1;
    localparam int PW  = SAMPLE_BITS + 18;
    localparam int SWW = PW - WIDTH_FRAC_BITS;
    localparam int AW  = SWW + 1;
    localparam int MW  = AW + GAIN_BITS + 1;
    localparam int RW  = MW - OUT_SHIFT;

    localparam logic [SWW-1:0] KNEE_T =
        SWW'(((64'd4 << SAMPLE_BITS) + 64'd2) / 64'd5);
    localparam logic [SWW-1:0]        KNEE_BIAS = SWW'(2) - KNEE_T;
    localparam logic signed [PW-1:0]  SIDE_HALF = PW'(1) << (WIDTH_FRAC_BITS - 1);
    localparam logic signed [MW-1:0]  OUT_HALF  = MW'(1) << (OUT_SHIFT - 1);
    localparam logic signed [RW-1:0]  OUT_MAX   =
        RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RW-1:0]  OUT_MIN   = RW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // Frame state carried through the knee stages.
    typedef struct packed {
        logic                  be;
        logic                  neg;
        logic                  over;
        logic signed [DW-1:0]  mid;
        logic signed [SWW-1:0] side;
        logic [SWW-1:0]        x;
        logic [SWW-1:0]        q;
    } t_knee;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_out(
        input logic signed [RW-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] res;
        if (v > OUT_MAX) begin
            res = SAMPLE_BITS'(OUT_MAX);
        end else if (v < OUT_MIN) begin
            res = SAMPLE_BITS'(OUT_MIN);
        end else begin
            res = SAMPLE_BITS'(v);
        end
        return res;
    endfunction

    t_gain_req  w_req;
    t_gain_stat w_gstat;

    logic [CFG_BITS-1:0] r_width;
    logic                w_cfg_ready, w_cfg_acc;
    logic                w_frm_ready, w_frm_acc;
    logic [NST-1:0]      r_v;
    logic [NST-1:0]      w_ld;

    logic signed [DW-1:0]  r0_mid, n0_mid, r0_diff, n0_diff;
    logic                  r0_be, r1_be;
    logic signed [DW-1:0]  r1_mid;
    logic signed [PW-1:0]  r1_prod, n1_prod;
    logic signed [16:0]    w_width_s;
    t_knee                 r2, n2, r3, n3, r4, n4, r5, n5, r6, n6, r7, n7, r8, n8;
    logic [SWW-1:0]        w_mag, w_q1, w_q2, w_q3, w_rem, w_mag2;
    logic [9:0]            w_corr;
    logic signed [AW-1:0]  r9_sum, n9_sum, r9_dif, n9_dif;
    logic                  r9_be, r10_be;
    logic signed [MW-1:0]  r10_psum, n10_psum, r10_pdif, n10_pdif;
    logic signed [GAIN_BITS:0] w_gain_s;
    logic signed [SAMPLE_BITS-1:0] r11_left, n11_left, r11_right, n11_right;
    logic                  r11_be;

    // Gain unit.
    swe_gain #(
        .WIDTH_FRAC_BITS (WIDTH_FRAC_BITS)
    ) u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_stat  (w_gstat)
    );

    // Width register writes only when nothing is in flight.
    assign w_cfg_ready = !w_gstat.busy && (r_v == '0);
    assign w_cfg_acc   = i_cfg.valid && w_cfg_ready;
    assign i_cfg.ready = w_cfg_ready;
    assign w_req.start = w_cfg_acc;
    assign w_req.width = r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (w_cfg_acc) begin
            r_width <= i_cfg.width_gain;
        end
    end

    // Stage load enables: a stage moves on when it is empty or its successor moves.
    always_comb begin
        w_ld[NST-1] = !r_v[NST-1] || o_frame.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_ld[k] = !r_v[k] || w_ld[k+1];
        end
    end

    assign w_frm_ready   = w_ld[0] && !w_gstat.busy && !w_cfg_acc;
    assign w_frm_acc     = i_frame.valid && w_frm_ready;
    assign i_frame.ready = w_frm_ready;

    // Valid bits travel with the frames.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_ld[0]) begin
                r_v[0] <= w_frm_acc;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 0: exact mid and side sums.
    assign n0_mid  = DW'(i_frame.left_sample) + DW'(i_frame.right_sample);
    assign n0_diff = DW'(i_frame.left_sample) - DW'(i_frame.right_sample);

    // Stage 1: side times width factor.
    assign w_width_s = {1'b0, r_width};
    assign n1_prod   = PW'(r0_diff) * PW'(w_width_s);

    // Stage 2: round the scaled side back to sample precision.
    always_comb begin
        n2      = r2;
        n2.be   = r1_be;
        n2.mid  = r1_mid;
        n2.side = SWW'((r1_prod + SIDE_HALF) >>> WIDTH_FRAC_BITS);
    end

    // Stage 3: magnitude, knee compare and excess plus rounding bias.
    always_comb begin
        n3      = r2;
        w_mag   = r2.side[SWW-1] ? SWW'(-r2.side) : SWW'(r2.side);
        n3.neg  = r2.side[SWW-1];
        n3.over = (w_mag > KNEE_T);
        n3.x    = w_mag + KNEE_BIAS;
    end

    // Stages 4 to 6: excess / 5 estimated by adding shifted copies (0.0011 0011 ...).
    always_comb begin
        n4   = r3;
        w_q1 = (r3.x >> 1) + (r3.x >> 2);
        n4.q = w_q1 + (w_q1 >> 4);
    end

    always_comb begin
        n5   = r4;
        w_q2 = r4.q + (r4.q >> 8);
        n5.q = w_q2 + (w_q2 >> 16);
    end

    always_comb begin
        n6   = r5;
        w_q3 = r5.q + (r5.q >> 32);
        n6.q = w_q3 >> 2;
    end

    // Stage 7: the estimate is low by a few units; fix it from the remainder.
    always_comb begin
        n7     = r6;
        w_rem  = r6.x - ((r6.q << 2) + r6.q);
        w_corr = {4'b0, w_rem[5:0]} * 10'd13;
        n7.q   = r6.q + SWW'(w_corr[9:6]);
    end

    // Stage 8: soft knee.
    always_comb begin
        n8     = r7;
        w_mag2 = KNEE_T + r7.q;
        if (r7.over) begin
            n8.side = r7.neg ? $signed(-w_mag2) : $signed(w_mag2);
        end
    end

    // Stage 9: left and right before the gain.
    assign n9_sum = AW'(r8.mid) + AW'(r8.side);
    assign n9_dif = AW'(r8.mid) - AW'(r8.side);

    // Stage 10: constant-power gain.
    assign w_gain_s = {1'b0, w_gstat.gain};
    assign n10_psum = MW'(r9_sum) * MW'(w_gain_s);
    assign n10_pdif = MW'(r9_dif) * MW'(w_gain_s);

    // Stage 11: round half up and saturate into the output register.
    assign n11_left  = sat_out(RW'((r10_psum + OUT_HALF) >>> OUT_SHIFT));
    assign n11_right = sat_out(RW'((r10_pdif + OUT_HALF) >>> OUT_SHIFT));

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r0_mid  <= n0_mid;
            r0_diff <= n0_diff;
            r0_be   <= i_frame.block_end;
        end
        if (w_ld[1]) begin
            r1_mid  <= r0_mid;
            r1_prod <= n1_prod;
            r1_be   <= r0_be;
        end
        if (w_ld[2]) begin
            r2 <= n2;
        end
        if (w_ld[3]) begin
            r3 <= n3;
        end
        if (w_ld[4]) begin
            r4 <= n4;
        end
        if (w_ld[5]) begin
            r5 <= n5;
        end
        if (w_ld[6]) begin
            r6 <= n6;
        end
        if (w_ld[7]) begin
            r7 <= n7;
        end
        if (w_ld[8]) begin
            r8 <= n8;
        end
        if (w_ld[9]) begin
            r9_sum <= n9_sum;
            r9_dif <= n9_dif;
            r9_be  <= r8.be;
        end
        if (w_ld[10]) begin
            r10_psum <= n10_psum;
            r10_pdif <= n10_pdif;
            r10_be   <= r9_be;
        end
        if (w_ld[11]) begin
            r11_left  <= n11_left;
            r11_right <= n11_right;
            r11_be    <= r10_be;
        end
    end

    assign o_frame.valid         = r_v[NST-1];
    assign o_frame.left_result   = r11_left;
    assign o_frame.right_result  = r11_right;
    assign o_frame.block_end_out = r11_be;

`ifndef SYNTHESIS
    // A width write always launches a gain calculation.
    a_cfg_starts_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready) |=> w_gstat.busy)
        else $error("width write did not start the gain unit");

    // The gain never changes under a frame in flight.
    a_gain_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v != '0) |=> $stable(w_gstat.gain))
        else $error("gain changed while frames were in the pipeline");

    // No frame enters while the gain is being recomputed.
    a_no_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_gstat.busy) && w_gstat.busy |-> !r_v[0])
        else $error("frame entered during gain calculation");
`endif

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the stereo width expander core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swe_pkg::*;

    localparam int     SB             = SAMPLE_BITS_DEF;
    localparam int     WF             = WIDTH_FRAC_BITS_DEF;
    localparam longint SAMPLE_MAX     = (longint'(1) << (SB - 1)) - 1;
    localparam longint SAMPLE_MIN     = -SAMPLE_MAX - 1;
    localparam longint KNEE           = ((longint'(4) << SB) + 2) / 5;
    localparam int     GAP_MAX        = 8;
    localparam int     DRAIN_CYCLES   = 24;
    localparam int     WATCHDOG_LIMIT = 2000;

    // One stereo frame, used both for stimulus and for predicted results.
    typedef struct packed {
        logic [SB-1:0] left;
        logic [SB-1:0] right;
        logic          block_end;
    } t_frame;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swe_cfg_if                         cfg_bus ();
    swe_frame_in_if  #(.SAMPLE_BITS(SB)) frame_in ();
    swe_frame_out_if #(.SAMPLE_BITS(SB)) frame_out ();

    stereo_width_expander_core #(
        .SAMPLE_BITS     (SB),
        .WIDTH_FRAC_BITS (WF)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_frame (frame_in),
        .o_frame (frame_out)
    );

    // Clock: 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Frames waiting to be sent and widened frames waiting to come out.
    t_frame frame_backlog [$];
    t_frame widened_queue [$];

    // Predictor copy of the width register and the derived output gain.
    logic [CFG_BITS-1:0]  width_now;
    logic [GAIN_BITS-1:0] gain_now;

    t_frame frame_now;
    bit     frame_busy;
    bit     frame_taken;
    int     frame_gap;
    bit     result_taken;
    int     sink_wait;
    bit     cfg_taken;
    bit     quiet_in;
    bit     quiet_out;
    int     phase_count;
    int     errors;
    int     frames_checked;
    int     widths_written;
    int     saturated_outputs;
    int     stuck_cycles;

    // Output gain for a width factor: rounded square root of 2^(33+2F) / (2^2F + w^2).
    function automatic logic [GAIN_BITS-1:0] gain_for_width(input logic [CFG_BITS-1:0] w);
        logic [63:0] ww;
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        ww    = w;
        den   = (64'd1 << (2 * WF)) + ww * ww;
        quo   = (64'd1 << (33 + 2 * WF)) / den;
        rem   = quo;
        root  = 64'd0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        // Digit-by-digit integer square root.
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        if (quo - root * root > root)
            root = root + 1;
        if (root > GAIN_MAX)
            root = GAIN_MAX;
        return root[GAIN_BITS-1:0];
    endfunction

    // Saturation to the signed sample range.
    function automatic logic [SB-1:0] clip_sample(input longint v);
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        if (v < SAMPLE_MIN)
            v = SAMPLE_MIN;
        return v[SB-1:0];
    endfunction

    // Widened frame for one input frame at a given width and gain.
    function automatic t_frame widen_frame(input t_frame f, input logic [CFG_BITS-1:0] w,
                                           input logic [GAIN_BITS-1:0] g);
        longint l;
        longint r;
        longint mid2;
        longint side;
        longint gain;
        t_frame res;
        l    = $signed(f.left);
        r    = $signed(f.right);
        gain = longint'(g);
        mid2 = l + r;
        side = ((l - r) * longint'(w) + (longint'(1) << (WF - 1))) >>> WF;
        // Soft knee: one fifth of the excess beyond the threshold, rounded on the magnitude.
        if (side > KNEE)
            side = KNEE + (side - KNEE + 2) / 5;
        else if (side < -KNEE)
            side = -KNEE - ((-side - KNEE + 2) / 5);
        res.left  = clip_sample(((mid2 + side) * gain + (longint'(1) << (OUT_SHIFT - 1)))
                                >>> OUT_SHIFT);
        res.right = clip_sample(((mid2 - side) * gain + (longint'(1) << (OUT_SHIFT - 1)))
                                >>> OUT_SHIFT);
        res.block_end = f.block_end;
        return res;
    endfunction

    function automatic int draw_gap(input bit quiet);
        if (quiet)
            return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    function automatic longint pick_extreme();
        case ($urandom_range(0, 5))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return SAMPLE_MAX - 1;
        endcase
    endfunction

    // Random frame: full range, extremes, small values, or a difference close to the knee.
    function automatic t_frame random_frame(input logic [CFG_BITS-1:0] w);
        t_frame      f;
        logic [31:0] raw;
        longint      target;
        longint      diff;
        longint      lo_r;
        longint      hi_r;
        longint      r;
        int          kind;
        kind = $urandom_range(0, 9);
        raw  = $urandom();
        f.left = raw[SB-1:0];
        raw  = $urandom();
        f.right = raw[SB-1:0];
        f.block_end = ($urandom_range(0, 7) == 0);
        if (kind >= 4 && kind <= 5) begin
            f.left  = clip_sample(pick_extreme());
            f.right = clip_sample(pick_extreme());
        end else if (kind >= 6 && kind <= 7 && w != 0) begin
            target = KNEE + longint'($urandom_range(0, 40)) - 20;
            if ($urandom_range(0, 1) == 1)
                target = -target;
            diff = (target <<< WF) / longint'(w);
            if (diff > 2 * SAMPLE_MAX + 1)
                diff = 2 * SAMPLE_MAX + 1;
            if (diff < -(2 * SAMPLE_MAX + 1))
                diff = -(2 * SAMPLE_MAX + 1);
            lo_r = (SAMPLE_MIN - diff > SAMPLE_MIN) ? SAMPLE_MIN - diff : SAMPLE_MIN;
            hi_r = (SAMPLE_MAX - diff < SAMPLE_MAX) ? SAMPLE_MAX - diff : SAMPLE_MAX;
            if (lo_r <= hi_r) begin
                r = lo_r + longint'($urandom_range(0, int'(hi_r - lo_r)));
                f.right = clip_sample(r);
                f.left  = clip_sample(r + diff);
            end
        end else if (kind >= 8) begin
            f.left  = clip_sample(longint'($urandom_range(0, 511)) - 256);
            f.right = clip_sample(longint'($urandom_range(0, 511)) - 256);
        end
        return f;
    endfunction

    task automatic push_frame(input longint l, input longint r, input bit be);
        t_frame f;
        f.left      = clip_sample(l);
        f.right     = clip_sample(r);
        f.block_end = be;
        frame_backlog.push_back(f);
    endtask

    task automatic fill_random(input int count);
        phase_count++;
        quiet_in  = (phase_count % 4 == 3) || ($urandom_range(0, 4) == 0);
        quiet_out = (phase_count % 4 == 3) || ($urandom_range(0, 4) == 0);
        repeat (count)
            frame_backlog.push_back(random_frame(width_now));
    endtask

    task automatic wait_idle();
        while (frame_backlog.size() != 0 || frame_busy || widened_queue.size() != 0)
            @(negedge i_clk);
    endtask

    // Width write, only once every outstanding frame has come out.
    task automatic write_width(input logic [CFG_BITS-1:0] w);
        wait_idle();
        @(negedge i_clk);
        cfg_taken = 1'b0;
        cfg_bus.valid      <= 1'b1;
        cfg_bus.width_gain <= w;
        while (!cfg_taken)
            @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Driver: one frame per beat, with a random gap before each new frame.
    always @(negedge i_clk) begin
        if (frame_taken) begin
            frame_busy  = 1'b0;
            frame_taken = 1'b0;
            frame_gap   = draw_gap(quiet_in);
        end
        if (!frame_busy && i_rst_n) begin
            if (frame_gap > 0) begin
                frame_gap--;
            end else if (frame_backlog.size() > 0) begin
                frame_now  = frame_backlog.pop_front();
                frame_busy = 1'b1;
            end
        end
        frame_in.valid        <= frame_busy;
        frame_in.left_sample  <= frame_now.left;
        frame_in.right_sample <= frame_now.right;
        frame_in.block_end    <= frame_now.block_end;
    end

    // Accepted input and configuration beats update the prediction.
    always @(posedge i_clk) begin
        t_frame f;
        if (cfg_bus.valid && cfg_bus.ready) begin
            width_now = cfg_bus.width_gain;
            gain_now  = gain_for_width(cfg_bus.width_gain);
            cfg_taken = 1'b1;
            widths_written++;
        end
        if (frame_in.valid && frame_in.ready) begin
            f.left      = frame_in.left_sample;
            f.right     = frame_in.right_sample;
            f.block_end = frame_in.block_end;
            widened_queue.push_back(widen_frame(f, width_now, gain_now));
            frame_taken = 1'b1;
        end
    end

    // Monitor back-pressure: ready is held low for a random stall after each result.
    always @(negedge i_clk) begin
        if (result_taken) begin
            result_taken = 1'b0;
            sink_wait    = draw_gap(quiet_out);
        end
        if (sink_wait > 0) begin
            sink_wait--;
            frame_out.ready <= 1'b0;
        end else begin
            frame_out.ready <= i_rst_n;
        end
    end

    // Monitor: each result beat is compared with the oldest predicted frame.
    always @(posedge i_clk) begin
        t_frame want;
        if (frame_out.valid && frame_out.ready) begin
            result_taken = 1'b1;
            if (widened_queue.size() == 0) begin
                $display("%0t: result beat with no frame outstanding, left %0d right %0d",
                         $time, frame_out.left_result, frame_out.right_result);
                errors++;
            end else begin
                want = widened_queue.pop_front();
                frames_checked++;
                if (want.left == SAMPLE_MAX[SB-1:0] || want.left == SAMPLE_MIN[SB-1:0])
                    saturated_outputs++;
                if (want.left !== frame_out.left_result) begin
                    $display("%0t: left_result expected %0d actual %0d", $time,
                             $signed(want.left), frame_out.left_result);
                    errors++;
                end
                if (want.right !== frame_out.right_result) begin
                    $display("%0t: right_result expected %0d actual %0d", $time,
                             $signed(want.right), frame_out.right_result);
                    errors++;
                end
                if (want.block_end !== frame_out.block_end_out) begin
                    $display("%0t: block_end_out expected %0b actual %0b", $time,
                             want.block_end, frame_out.block_end_out);
                    errors++;
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((frame_in.valid && frame_in.ready) || (frame_out.valid && frame_out.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d frames outstanding", $time,
                     stuck_cycles, widened_queue.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus: phases at several widths; the first three open with a few directed frames, all go on with random ones.
    initial begin
        logic [CFG_BITS-1:0] width_list [7];
        i_rst_n               = 1'b0;
        frame_in.valid        = 1'b0;
        frame_in.left_sample  = '0;
        frame_in.right_sample = '0;
        frame_in.block_end    = 1'b0;
        frame_out.ready       = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.width_gain    = '0;
        width_now             = WIDTH_RESET;
        gain_now              = gain_for_width(WIDTH_RESET);
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset width: full-scale frames and the knee boundary on both sides.
        push_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        push_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        push_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        push_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        push_frame(0, 0, 1'b0);
        push_frame(-1, 1, 1'b1);
        push_frame(SAMPLE_MAX, SAMPLE_MAX - KNEE, 1'b0);
        push_frame(SAMPLE_MAX, SAMPLE_MAX - KNEE - 2, 1'b0);
        push_frame(SAMPLE_MAX, SAMPLE_MAX - KNEE - 3, 1'b1);
        push_frame(SAMPLE_MIN, SAMPLE_MIN + KNEE + 3, 1'b0);
        fill_random(110);

        // Width zero: the side signal vanishes and the gain is close to root two.
        write_width(16'd0);
        push_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        push_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        push_frame(12345, -54321, 1'b0);
        fill_random(110);

        // Widest setting: the knee and the saturation do most of the work.
        write_width(16'hffff);
        push_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        push_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        push_frame(4096, -4096, 1'b0);
        push_frame(0, 0, 1'b1);
        fill_random(110);

        width_list = '{16'd1, WIDTH_RESET, 16'd8192, 16'd32768, 16'd49152,
                       16'($urandom()), 16'($urandom())};
        foreach (width_list[i]) begin
            write_width(width_list[i]);
            fill_random(70);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (widened_queue.size() != 0) begin
            $display("%0t: %0d predicted frames never came out", $time, widened_queue.size());
            errors++;
        end
        $display("Checked %0d widened frames over %0d width writes and the reset width,",
                 frames_checked, widths_written);
        $display("with %0d saturated left results and %0d mismatches.",
                 saturated_outputs, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/swe_pkg.sv
hw/rtl/swe_frame_in_if.sv
hw/rtl/swe_frame_out_if.sv
hw/rtl/swe_cfg_if.sv
hw/rtl/swe_gain.sv
hw/rtl/stereo_width_expander_core.sv
bench/tb_top.sv
